// ----- hdl/bc1_pkg.sv -----
package bc1_pkg;

  localparam int COLOUR_W = 24;
  localparam int TEXELS_PER_ROW = 4;
  localparam int PALETTE_SIZE = 4;
  localparam int INDEX_W = 32;
  localparam int ROW_W = 2;
  localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;

  // One decoded block as it waits between the front and the back.
  typedef struct packed {
    logic [PALETTE_SIZE-1:0][COLOUR_W-1:0] palette;
    logic [INDEX_W-1:0] index_bits;
  } block_entry_t;

endpackage

// ----- hdl/bc1_front.sv -----
module bc1_front
  import bc1_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  first_colour,
  input  logic [15:0]  second_colour,
  input  logic [31:0]  index_bits,
  output logic         push_valid,
  input  logic         push_ready,
  output block_entry_t push_entry
);

  // x / 3 for x below 768 equals (x * 683) >> 11.
  localparam logic [19:0] MIX_RECIP = 20'd683;

  // Bit replication of an RGB565 colour to 8 bits per channel.
  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  // Per channel (2 * near + far + 1) / 3.
  function automatic logic [23:0] third_mix(input logic [23:0] near_c,
                                            input logic [23:0] far_c);
    logic [9:0]  s;
    logic [19:0] p;
    logic [23:0] m;
    m = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = 10'({near_c[8*ch +: 8], 1'b0}) + 10'(far_c[8*ch +: 8]) + 10'd1;
      p = 20'(s) * MIX_RECIP;
      m[8*ch +: 8] = p[18:11];
    end
    return m;
  endfunction

  logic         valid;
  block_entry_t entry;
  logic [23:0]  c0;
  logic [23:0]  c1;

  assign c0 = expand565(first_colour);
  assign c1 = expand565(second_colour);

  // The stage takes a new block whenever it is empty or its block moves on.
  assign in_ready = !valid || push_ready;
  assign push_valid = valid;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Palette is built while the block is taken in.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry.palette[0] <= c0;
      entry.palette[1] <= c1;
      entry.palette[2] <= third_mix(c0, c1);
      entry.palette[3] <= third_mix(c1, c0);
      entry.index_bits <= index_bits;
    end
  end

endmodule

// ----- hdl/bc1_queue.sv -----
module bc1_queue
  import bc1_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  block_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output block_entry_t pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  block_entry_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on a lone push");
`endif

endmodule

// ----- hdl/bc1_back.sv -----
module bc1_back
  import bc1_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  block_entry_t pop_entry,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [95:0]  out_data,
  output logic [1:0]   out_row,
  output logic         out_last
);

  logic [ROW_W-1:0]                                row;
  logic                                            advance;
  logic [TEXELS_PER_ROW-1:0][COLOUR_W-1:0]         texels;

  // The output register moves when empty or when its row is taken.
  assign advance = !out_valid || out_ready;
  // The block leaves the queue with its last row.
  assign pop_ready = advance && (row == ROW_LAST);

  // Palette lookup for the four texels of the current row.
  always_comb begin
    for (int col = 0; col < TEXELS_PER_ROW; col++) begin
      texels[col] = pop_entry.palette[pop_entry.index_bits[{row, 2'(col), 1'b0} +: 2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row <= '0;
    end else if (advance) begin
      out_valid <= pop_valid;
      if (pop_valid) begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pop_valid) begin
      out_data <= texels;
      out_row <= row;
      out_last <= (row == ROW_LAST);
    end
  end

`ifndef SYNTHESIS
  a_last_marks_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_row == ROW_LAST)))
    else $error("last flag does not match row");

  a_rows_unbroken: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a block");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid || (out_row == ROW_W'($past(out_row) + 1'b1)))
    else $error("rows out of order");
`endif

endmodule

// ----- hdl/bc1_block_decoder_core.sv -----
// BC1 block decoder, four-colour mode.
// Input stream s_axis: one request carries one compressed 4x4 block, two RGB565
// endpoints and sixteen 2-bit palette indices. Output stream m_axis: four
// requests per block, one per texel row from the top, each with four 24-bit
// texels 0xRRGGBB, the row number in tuser and tlast on the fourth row.
// The first row of a block is presented once the block has passed the front
// stage register, the queue and the output register; the other rows follow one
// per cycle while m_axis_tready is high, and the output port, moving one row
// per cycle, bounds the block rate. The front stage expands the endpoints and
// forms the two interpolated colours; a queue of QUEUE_DEPTH blocks sits
// between it and the row sequencer, so input keeps flowing while a row waits at
// the output. When the receiver stalls, the current row holds on m_axis, the
// queue fills and then s_axis_tready drops. Reset empties the front stage, the
// queue and the output register; no block is in flight afterwards.
module bc1_block_decoder_core
  import bc1_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // first_colour, second_colour, index_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // texel_a, texel_b, texel_c, texel_d
  output logic [1:0]  m_axis_tuser,  // row_number
  output logic        m_axis_tlast
);

  logic         push_valid;
  logic         push_ready;
  block_entry_t push_entry;
  logic         pop_valid;
  logic         pop_ready;
  block_entry_t pop_entry;

  bc1_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .first_colour  (s_axis_tdata[15:0]),
    .second_colour (s_axis_tdata[31:16]),
    .index_bits    (s_axis_tdata[63:32]),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  bc1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  bc1_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_row   (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import bc1_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BLOCKS = 300;

  // One expected texel row: four texels (column 0 lowest), row number and last flag.
  typedef struct packed {
    logic [TEXELS_PER_ROW-1:0][COLOUR_W-1:0] texels;
    logic [ROW_W-1:0] row_number;
    logic last_row;
  } texel_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // first_colour, second_colour, index_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // texel_a, texel_b, texel_c, texel_d
  logic [1:0]  m_axis_tuser;   // row_number
  logic        m_axis_tlast;

  texel_row_t rows_due[$];
  int errors = 0;
  int cycles = 0;
  int in_gap_max = 15;
  int out_stall_max = 15;

  bc1_block_decoder_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Replicate the top bits into the low bits to widen a channel to 8 bits.
  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [COLOUR_W-1:0] expand_rgb565(logic [15:0] c);
    return {widen5(c[15:11]), widen6(c[10:5]), widen5(c[4:0])};
  endfunction

  // Per channel (2*near + far + 1) / 3, truncating.
  function automatic logic [COLOUR_W-1:0] blend_third(logic [COLOUR_W-1:0] near_c,
                                                      logic [COLOUR_W-1:0] far_c);
    logic [COLOUR_W-1:0] mix;
    int a;
    int b;
    for (int ch = 0; ch < 3; ch++) begin
      a = near_c[8*ch +: 8];
      b = far_c[8*ch +: 8];
      mix[8*ch +: 8] = 8'((2 * a + b + 1) / 3);
    end
    return mix;
  endfunction

  // Build the palette and queue the four rows this block must produce.
  task automatic predict_rows(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [31:0] idx);
    logic [PALETTE_SIZE-1:0][COLOUR_W-1:0] palette;
    texel_row_t r;
    palette[0] = expand_rgb565(c0);
    palette[1] = expand_rgb565(c1);
    palette[2] = blend_third(palette[0], palette[1]);
    palette[3] = blend_third(palette[1], palette[0]);
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < TEXELS_PER_ROW; col++) begin
        r.texels[col] = palette[idx[2 * (4 * row + col) +: 2]];
      end
      r.row_number = ROW_W'(row);
      r.last_row = (ROW_W'(row) == ROW_LAST);
      rows_due.push_back(r);
    end
  endtask

  // Send one block request after a random gap; valid stays high for the next call.
  task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [31:0] idx);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {idx, c1, c0};
    do @(posedge clk); while (!s_axis_tready);
    predict_rows(c0, c1, idx);
  endtask

  // Compare one accepted row with the oldest expected row.
  task automatic check_row;
    texel_row_t want;
    if (rows_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected row: tdata %h tuser %0d tlast %b",
               $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      return;
    end
    want = rows_due.pop_front();
    for (int col = 0; col < TEXELS_PER_ROW; col++) begin
      if (m_axis_tdata[col*COLOUR_W +: COLOUR_W] !== want.texels[col]) begin
        errors++;
        $display("%0t: texel %0d: expected %h actual %h", $time, col,
                 want.texels[col], m_axis_tdata[col*COLOUR_W +: COLOUR_W]);
      end
    end
    if (m_axis_tuser !== want.row_number) begin
      errors++;
      $display("%0t: row_number: expected %0d actual %0d", $time,
               want.row_number, m_axis_tuser);
    end
    if (m_axis_tlast !== want.last_row) begin
      errors++;
      $display("%0t: last_row: expected %b actual %b", $time, want.last_row, m_axis_tlast);
    end
  endtask

  // Receiver: stall a random number of cycles before each row, then check it.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_row();
    end
  end

  // Extreme endpoints, every palette index, both endpoint orders and equal endpoints.
  task automatic test_directed_blocks;
    send_block(16'h0000, 16'h0000, 32'h0000_0000);
    send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
    send_block(16'hFFFF, 16'h0000, 32'h1B1B_1B1B);
    send_block(16'hF800, 16'h001F, 32'h5555_5555);
    send_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
    send_block(16'h07E0, 16'h0000, 32'hE4E4_E4E4);
    send_block(16'h0000, 16'h07E0, 32'h4E4E_4E4E);
    send_block(16'h1234, 16'h1234, 32'hE4E4_E4E4);
    send_block(16'h8410, 16'h7BEF, 32'h0123_4567);
    send_block(16'h0821, 16'hF7DE, 32'h89AB_CDEF);
    send_block(16'hFFFF, 16'hFFFE, 32'hFEDC_BA98);
  endtask

  function automatic logic [15:0] pick_endpoint;
    logic [15:0] extremes [5] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
    if ($urandom_range(3, 0) == 0) return extremes[$urandom_range(4, 0)];
    return 16'($urandom);
  endfunction

  // Random blocks with the idling limits changed every fifty blocks.
  task automatic test_random_blocks;
    int limits [3] = '{0, 3, 15};
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] idx;
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      if (n % 50 == 0) begin
        in_gap_max = limits[$urandom_range(2, 0)];
        out_stall_max = limits[$urandom_range(2, 0)];
      end
      c0 = pick_endpoint();
      c1 = ($urandom_range(9, 0) == 0) ? c0 : pick_endpoint();
      idx = $urandom;
      if ($urandom_range(9, 0) == 0) idx = {16{2'($urandom_range(3, 0))}};
      send_block(c0, c1, idx);
    end
  endtask

  // Back-to-back blocks at full rate, then with output back-pressure, then sparse input.
  task automatic test_streaming_blocks;
    in_gap_max = 0;
    out_stall_max = 0;
    for (int n = 0; n < 60; n++) begin
      if (n == 30) out_stall_max = 15;
      if (n == 45) begin
        in_gap_max = 15;
        out_stall_max = 0;
      end
      send_block(16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  // Reset, run each test in turn, drain and report.
  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_blocks();
    test_random_blocks();
    test_streaming_blocks();
    s_axis_tvalid <= 1'b0;
    out_stall_max = 15;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
